// ===== src/gdst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdst_pkg
// Shared types and constants for the graphical degree sequence test.
// ----------------------------------------------------------------------------
package gdst_pkg;

  localparam int DEG_W = 8;
  localparam int NBINS = 256;

  typedef logic [DEG_W-1:0] deg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_B_SWAIT,
    ST_B_HADDR,
    ST_B_HWAIT,
    ST_B_HUPD,
    ST_ROUND,
    ST_F_WAIT,
    ST_F_CHK,
    ST_W_PROC,
    ST_W_WAIT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic build_init;
    logic seq_clear;
    logic haddr_from_sdata;
    logic build_update;
    logic round_init;
    logic find_step;
    logic find_hit;
    logic walk_proc;
    logic out_set;
    logic out_graph;
    logic out_long;
  } cmd_t;

  typedef struct packed {
    logic ovf_now;
    logic out_free;
    logic last_build;
    logic live_zero;
    logic bin_nonzero;
    logic top_ok;
    logic walk_more;
  } status_t;

endpackage
`default_nettype wire

// ===== src/gdst_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdst_ctrl
// Sequencer: load, histogram build, and Havel-Hakimi rounds over the bins.
// ----------------------------------------------------------------------------
module gdst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire gdst_pkg::status_t status,
  output gdst_pkg::cmd_t         cmd
);
  import gdst_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_LOAD) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load_en = accept;
        if (accept && in_last) begin
          if (status.ovf_now) begin
            cmd.out_set   = 1'b1;
            cmd.out_long  = 1'b1;
            cmd.seq_clear = 1'b1;
          end else begin
            cmd.build_init = 1'b1;
            state_next     = ST_B_SWAIT;
          end
        end
      end
      ST_B_SWAIT: state_next = ST_B_HADDR;
      ST_B_HADDR: begin
        cmd.haddr_from_sdata = 1'b1;
        state_next           = ST_B_HWAIT;
      end
      ST_B_HWAIT: state_next = ST_B_HUPD;
      ST_B_HUPD: begin
        cmd.build_update = 1'b1;
        state_next       = status.last_build ? ST_ROUND : ST_B_SWAIT;
      end
      ST_ROUND: begin
        if (status.live_zero) begin
          cmd.out_set   = 1'b1;
          cmd.out_graph = 1'b1;
          cmd.seq_clear = 1'b1;
          state_next    = ST_LOAD;
        end else begin
          cmd.round_init = 1'b1;
          state_next     = ST_F_WAIT;
        end
      end
      ST_F_WAIT: state_next = ST_F_CHK;
      ST_F_CHK: begin
        if (status.bin_nonzero) begin
          if (status.top_ok) begin
            cmd.find_hit = 1'b1;
            state_next   = ST_W_PROC;
          end else begin
            cmd.out_set   = 1'b1;
            cmd.seq_clear = 1'b1;
            state_next    = ST_LOAD;
          end
        end else begin
          cmd.find_step = 1'b1;
          state_next    = ST_F_WAIT;
        end
      end
      ST_W_PROC: begin
        cmd.walk_proc = 1'b1;
        state_next    = status.walk_more ? ST_W_WAIT : ST_ROUND;
      end
      ST_W_WAIT: state_next = ST_W_PROC;
      default:   state_next = ST_LOAD;
    endcase
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_set |-> status.out_free)
    else $error("result written while output slot busy");

  a_build_leaves_load: assert property (@(posedge clk) disable iff (rst)
    cmd.build_init |=> !in_ready)
    else $error("input taken during test");

  a_hit_goes_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.find_hit |=> (state == ST_W_PROC))
    else $error("walk not started after top found");

endmodule
`default_nettype wire

// ===== src/gdst_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gdst_datapath
// Degree store, degree histogram, counters and the result register.
// ----------------------------------------------------------------------------
module gdst_datapath #(
  parameter int SEQ_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gdst_pkg::cmd_t    cmd,
  output gdst_pkg::status_t      status,
  input  wire gdst_pkg::deg_t    in_degree,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   out_graphical,
  output logic                   out_too_long
);
  import gdst_pkg::*;

  localparam int AW   = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CW   = $clog2(SEQ_DEPTH + 1);
  localparam int CMPW = (CW > DEG_W) ? CW : DEG_W;

  logic [DEG_W-1:0] store [SEQ_DEPTH];
  logic [CW-1:0]    hist  [NBINS];
  logic [NBINS-1:0] bin_valid;

  logic [CW-1:0]    count;
  logic             overflow;
  deg_t             max_deg;
  logic [AW-1:0]    idx;
  deg_t             sdata;
  deg_t             haddr;
  logic [CW-1:0]    hdata;
  logic             hval;
  logic [CW-1:0]    live;
  deg_t             v;
  deg_t             top;
  deg_t             rem;
  logic [CMPW-1:0]  carry;
  logic             first;

  logic             full;
  logic [CW-1:0]    eff;
  logic [CW-1:0]    cur;
  logic [CMPW-1:0]  take;
  deg_t             rem_new;
  logic             hist_we;
  logic [CW-1:0]    hist_wdata;

  assign full = (count == CW'(SEQ_DEPTH));
  assign eff  = hval ? hdata : '0;
  assign cur  = eff - CW'(first);
  assign take = (CMPW'(cur) < CMPW'(rem)) ? CMPW'(cur) : CMPW'(rem);
  assign rem_new = rem - take[DEG_W-1:0];

  assign hist_we    = cmd.build_update || cmd.walk_proc;
  assign hist_wdata = cmd.build_update ? (eff + CW'(1))
                                       : CW'(CMPW'(cur) - take + carry);

  always_comb begin
    status             = '0;
    status.ovf_now     = overflow || full;
    status.out_free    = !out_valid || out_ready;
    status.last_build  = ((CW'(idx) + CW'(1)) == count);
    status.live_zero   = (live == '0);
    status.bin_nonzero = (eff != '0);
    status.top_ok      = (CMPW'(v) < CMPW'(live));
    status.walk_more   = ((rem_new != '0) || (take != '0)) && (v != DEG_W'(1));
  end

  // store and histogram memories
  always_ff @(posedge clk) begin
    if (cmd.load_en && !full) begin
      store[count[AW-1:0]] <= in_degree;
    end
    sdata <= store[idx];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[haddr] <= hist_wdata;
    end
    hdata <= hist[haddr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.build_init) begin
      bin_valid <= '0;
    end else if (hist_we) begin
      bin_valid[haddr] <= 1'b1;
    end
    hval <= bin_valid[haddr];
  end

  // sequence counters
  always_ff @(posedge clk) begin
    if (rst || cmd.seq_clear) begin
      count    <= '0;
      overflow <= 1'b0;
      max_deg  <= '0;
    end else if (cmd.load_en) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + CW'(1);
        if (in_degree > max_deg) begin
          max_deg <= in_degree;
        end
      end
    end
  end

  // test datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      live  <= '0;
      first <= 1'b0;
    end else begin
      if (cmd.build_init) begin
        idx  <= '0;
        live <= '0;
      end
      if (cmd.haddr_from_sdata) begin
        haddr <= sdata;
      end
      if (cmd.build_update) begin
        idx  <= idx + AW'(1);
        live <= live + CW'(sdata != '0);
        top  <= max_deg;
      end
      if (cmd.round_init) begin
        haddr <= top;
        v     <= top;
      end
      if (cmd.find_step) begin
        haddr <= v - DEG_W'(1);
        v     <= v - DEG_W'(1);
      end
      if (cmd.find_hit) begin
        top   <= v;
        rem   <= v;
        carry <= '0;
        first <= 1'b1;
        live  <= live - CW'(1);
      end
      if (cmd.walk_proc) begin
        carry <= take;
        rem   <= rem_new;
        first <= 1'b0;
        haddr <= v - DEG_W'(1);
        v     <= v - DEG_W'(1);
        if (v == DEG_W'(1)) begin
          live <= live - CW'(take);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_set) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_set) begin
      out_graphical <= cmd.out_graph;
      out_too_long  <= cmd.out_long;
    end
  end

  a_scan_above_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.find_step |-> (v > DEG_W'(1)))
    else $error("top search ran below bin one");

  a_walk_complete: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_proc && (v == DEG_W'(1))) |-> (rem_new == '0))
    else $error("walk ran out of entries");

  a_hit_nonzero_live: assert property (@(posedge clk) disable iff (rst)
    cmd.find_hit |-> (live != '0))
    else $error("top found with no live entries");

endmodule
`default_nettype wire

// ===== src/graphical_degree_sequence_test_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// graphical_degree_sequence_test_top
// Havel-Hakimi test of a degree sequence streamed in one degree per beat.
// ----------------------------------------------------------------------------
// Load: one degree per cycle; input stalls during the test and while a result waits.
// After the last beat, each stored degree is read and counted into a degree histogram;
// each round then scans down from the top bin for a nonempty bin and walks down from
// that bin through the one-port bin memory; a round with no live degree ends the test.
// The result is registered when the test ends; too_long is registered on the last beat.
// Reset clears the sequencer, counters and histogram valid bits, not memories.
module graphical_degree_sequence_test_top #(
  parameter int SEQ_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] degree
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] graphical, [1] too_long, [7:2] zero
);
  import gdst_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    graphical;
  logic    too_long;

  gdst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gdst_datapath #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_degree     (s_axis_tdata),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_graphical (graphical),
    .out_too_long  (too_long)
  );

  assign m_axis_tdata = {6'b000000, too_long, graphical};

endmodule
`default_nettype wire

// ===== bench/tb_graphical_degree_sequence_test_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graphical_degree_sequence_test_top
// Streams degree sequences into the Havel-Hakimi tester and checks every
// verdict. A short directed table comes first, then random sequences: mostly
// degree lists of real random graphs, some with one degree bent, some random
// noise and a few that overflow the store. Sender gaps and receiver stalls
// rotate through several patterns. A local predictor gives each unpinned verdict.
// ----------------------------------------------------------------------------
module tb_graphical_degree_sequence_test_top;

  import gdst_pkg::*;

  localparam int SEQ_DEPTH   = 64;
  localparam int ITEMS       = 1350;
  localparam int QUIET_LIMIT = 400000;

  typedef struct packed {
    logic too_long;
    logic graphical;
  } verdict_t;

  typedef struct packed {
    logic     pinned;
    verdict_t v;
  } close_note_t;

  typedef struct packed {
    deg_t       degree;
    logic       last;
    logic [7:0] reps;
    logic       pinned;
    logic       graphical;
    logic       too_long;
  } stim_row_t;

  localparam int DIR_N = 22;
  localparam stim_row_t DIR_ROWS [DIR_N] = '{
    '{8'd0,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
    '{8'd1,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
    '{8'd255, 1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
    '{8'd1,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{8'd1,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
    '{8'd0,   1'b0, 8'd5,  1'b0, 1'b0, 1'b0},
    '{8'd0,   1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
    '{8'd3,   1'b0, 8'd2,  1'b0, 1'b0, 1'b0},
    '{8'd3,   1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
    '{8'd3,   1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{8'd1,   1'b0, 8'd2,  1'b0, 1'b0, 1'b0},
    '{8'd1,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
    '{8'd2,   1'b0, 8'd3,  1'b0, 1'b0, 1'b0},
    '{8'd2,   1'b1, 8'd1,  1'b0, 1'b0, 1'b0},
    '{8'd170, 1'b0, 8'd1,  1'b0, 1'b0, 1'b0},
    '{8'd85,  1'b1, 8'd1,  1'b1, 1'b0, 1'b0},
    '{8'd63,  1'b0, 8'd63, 1'b0, 1'b0, 1'b0},
    '{8'd63,  1'b1, 8'd1,  1'b1, 1'b1, 1'b0},
    '{8'd255, 1'b0, 8'd64, 1'b0, 1'b0, 1'b0},
    '{8'd7,   1'b1, 8'd1,  1'b1, 1'b0, 1'b1},
    '{8'd0,   1'b0, 8'd64, 1'b0, 1'b0, 1'b0},
    '{8'd0,   1'b1, 8'd1,  1'b1, 1'b0, 1'b1}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] degree
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [0] graphical, [1] too_long, [7:2] zero

  deg_t        held [SEQ_DEPTH];
  int          held_n = 0;
  bit          held_overflow = 1'b0;
  close_note_t close_notes [$];
  verdict_t    verdicts_due [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int beats_sent   = 0;
  int seqs_closed  = 0;
  int n_graphical  = 0;
  int n_rejected   = 0;
  int n_too_long   = 0;
  int errors       = 0;
  int quiet_cycles = 0;

  graphical_degree_sequence_test_top #(
    .SEQ_DEPTH(SEQ_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // Havel-Hakimi on the first n held degrees
  function automatic bit havel_hakimi_ok(input int n);
    int work [SEQ_DEPTH];
    int i, j, key, live, top;
    bit ok, done;
    ok = 1'b1;
    done = 1'b0;
    for (i = 0; i < n; i++) work[i] = held[i];
    while (!done) begin
      for (i = 1; i < n; i++) begin
        key = work[i];
        j = i;
        while (j > 0 && work[j-1] < key) begin
          work[j] = work[j-1];
          j--;
        end
        work[j] = key;
      end
      live = 0;
      while (live < n && work[live] != 0) live++;
      if (live == 0) begin
        done = 1'b1;
      end else begin
        top = work[0];
        work[0] = 0;
        if (top > live - 1) begin
          ok = 1'b0;
          done = 1'b1;
        end else begin
          for (i = 1; i <= top; i++) work[i] = work[i] - 1;
        end
      end
    end
    return ok;
  endfunction

  task automatic send_beat(input deg_t d, input logic l);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : monitor
    close_note_t note;
    verdict_t    v;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (held_n < SEQ_DEPTH) begin
          held[held_n] = s_axis_tdata;
          held_n++;
        end else begin
          held_overflow = 1'b1;
        end
        if (s_axis_tlast) begin
          note = (close_notes.size() != 0) ? close_notes.pop_front() : '0;
          if (note.pinned) begin
            v = note.v;
          end else if (held_overflow) begin
            v = '{too_long: 1'b1, graphical: 1'b0};
          end else begin
            v = '{too_long: 1'b0, graphical: havel_hakimi_ok(held_n)};
          end
          verdicts_due.push_back(v);
          held_n = 0;
          held_overflow = 1'b0;
          seqs_closed++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result beat with nothing pending", m_axis_tdata, -1);
        end else begin
          v = verdicts_due.pop_front();
          if (m_axis_tdata[0] !== v.graphical) begin
            report_mismatch("graphical", m_axis_tdata[0], v.graphical);
          end
          if (m_axis_tdata[1] !== v.too_long) begin
            report_mismatch("too_long", m_axis_tdata[1], v.too_long);
          end
          if (m_axis_tdata[7:2] !== 6'd0) begin
            report_mismatch("tdata padding", m_axis_tdata[7:2], 0);
          end
          if (v.too_long) n_too_long++;
          else if (v.graphical) n_graphical++;
          else n_rejected++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d verdicts outstanding",
               quiet_cycles, verdicts_due.size());
      $display("** graphical_degree_sequence_test_top: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int   r, rep, i, j, n, p, kind, seq_no, pick;
    logic closing;
    deg_t degs [$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < DIR_N; r++) begin
      for (rep = 0; rep < DIR_ROWS[r].reps; rep++) begin
        closing = DIR_ROWS[r].last && (rep == DIR_ROWS[r].reps - 1);
        if (closing) begin
          close_notes.push_back({DIR_ROWS[r].pinned, DIR_ROWS[r].too_long,
                                 DIR_ROWS[r].graphical});
        end
        send_beat(DIR_ROWS[r].degree, closing);
      end
    end

    seq_no = 0;
    while (beats_sent < ITEMS) begin
      case ((seq_no / 8) % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      kind = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      degs = {};
      if (kind < 80) begin
        // degrees of a random graph, sometimes with one degree bent
        if (pick < 90) n = $urandom_range(1, 12);
        else if (pick < 98) n = $urandom_range(13, 32);
        else n = $urandom_range(33, SEQ_DEPTH);
        p = $urandom_range(0, 100);
        for (i = 0; i < n; i++) degs.push_back(8'd0);
        for (i = 0; i < n; i++) begin
          for (j = i + 1; j < n; j++) begin
            if ($urandom_range(0, 99) < p) begin
              degs[i] = degs[i] + 8'd1;
              degs[j] = degs[j] + 8'd1;
            end
          end
        end
        if (kind >= 60) begin
          i = $urandom_range(0, n - 1);
          case ($urandom_range(0, 3))
            0: degs[i] = degs[i] + 8'd1;
            1: if (degs[i] != 0) degs[i] = degs[i] - 8'd1;
               else degs[i] = 8'd1;
            2: degs[i] = deg_t'($urandom_range(0, n));
            default: degs[i] = deg_t'($urandom_range(0, 255));
          endcase
        end
      end else if (kind < 98) begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
          if (pick < 50) degs.push_back(deg_t'($urandom_range(0, n)));
          else degs.push_back(deg_t'($urandom_range(0, 255)));
        end
      end else begin
        n = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 8);
        for (i = 0; i < n; i++) degs.push_back(deg_t'($urandom_range(0, 255)));
      end
      for (i = 0; i < degs.size(); i++) begin
        closing = (i == degs.size() - 1);
        if (closing) close_notes.push_back('0);
        send_beat(degs[i], closing);
      end
      seq_no++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("run covered %0d sequences over %0d degree beats", seqs_closed, beats_sent);
    $display("verdicts seen: %0d graphical, %0d rejected, %0d overflowed; %0d mismatches",
             n_graphical, n_rejected, n_too_long, errors);
    if (errors == 0) begin
      $display("** graphical_degree_sequence_test_top: PASSED **");
    end else begin
      $display("** graphical_degree_sequence_test_top: FAILED **");
    end
    $finish;
  end

endmodule
